// File: rtl/core/tsf_pkg.sv
// Shared types, constants and helper function of the telemetry slot framer.
package tsf_pkg;

  localparam int SLOT_COUNT_DEF      = 32;
  localparam int SLOTS_PER_GROUP_DEF = 8;
  localparam int FRAME_LENGTH_DEF    = 25;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [7:0] START_BYTE  = 8'h0f;
  localparam logic [7:0] END_GROUP0  = 8'h04;
  localparam logic [7:0] END_GROUP1  = 8'h14;
  localparam logic [7:0] END_GROUP2  = 8'h24;
  localparam logic [7:0] END_GROUP3  = 8'h34;
  localparam logic [2:0] ID_LOW_BITS = 3'b011;

  typedef struct packed {
    logic        burst;
    logic [1:0]  group;
    logic [4:0]  idx;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_t;

  function automatic logic [7:0] slot_id(logic [4:0] n);
    return {n[0], n[1], n[2], n[3], n[4], ID_LOW_BITS};
  endfunction

endpackage

// File: rtl/core/tsf_fifo.sv
// Small first-in first-out queue of words.
module tsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/tsf_front.sv
// Front end: tracks the channel frame and turns words into slot writes and bursts.
module tsf_front #(
  parameter int SLOT_COUNT   = tsf_pkg::SLOT_COUNT_DEF,
  parameter int FRAME_LENGTH = tsf_pkg::FRAME_LENGTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          command_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [4:0]    slot_index_i,
  input  logic [15:0]   slot_value_i,
  output logic          cmd_push_o,
  output tsf_pkg::cmd_t cmd_o
);

  logic [4:0] pos_q, pos_d;
  logic       enq;

  always_comb begin
    pos_d       = pos_q;
    enq         = 1'b0;
    cmd_o       = '0;
    cmd_o.idx   = slot_index_i;
    cmd_o.value = slot_value_i;
    if (command_i) begin
      enq = ({1'b0, slot_index_i} < 6'(SLOT_COUNT));
    end else if (pos_q == '0) begin
      pos_d = (rx_byte_i == tsf_pkg::START_BYTE) ? 5'd1 : 5'd0;
    end else if (pos_q < 5'(FRAME_LENGTH - 1)) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d       = '0;
      cmd_o.burst = 1'b1;
      enq         = 1'b1;
      unique case (rx_byte_i)
        tsf_pkg::END_GROUP0: cmd_o.group = 2'd0;
        tsf_pkg::END_GROUP1: cmd_o.group = 2'd1;
        tsf_pkg::END_GROUP2: cmd_o.group = 2'd2;
        tsf_pkg::END_GROUP3: cmd_o.group = 2'd3;
        default:             enq = 1'b0;
      endcase
    end
  end

  assign cmd_push_o = accept_i && enq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/core/tsf_back.sv
// Back end: holds the slot store and emits the telemetry bytes of a group.
module tsf_back #(
  parameter int SLOT_COUNT      = tsf_pkg::SLOT_COUNT_DEF,
  parameter int SLOTS_PER_GROUP = tsf_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  tsf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output tsf_pkg::out_t out_o
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int KW = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_LO   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [KW-1:0]         k_q, k_d;
  logic [1:0]            group_q, group_d;
  logic [SLOT_COUNT-1:0] written_q;
  logic [15:0]           rd_q;
  logic [15:0]           mem [SLOT_COUNT];
  logic [5:0]            n;
  logic                  slot_ok, k_last, last, wr_en;
  logic [SLOTS_PER_GROUP-1:0] gm, hi_mask;

  assign n       = 6'(group_q) * 6'(SLOTS_PER_GROUP) + 6'(k_q);
  assign slot_ok = (n < 6'(SLOT_COUNT)) && written_q[n[AW-1:0]];
  assign k_last  = (k_q == KW'(SLOTS_PER_GROUP - 1));
  assign last    = ((gm & hi_mask) == '0);

  always_comb begin
    logic [5:0] nj;
    for (int j = 0; j < SLOTS_PER_GROUP; j++) begin
      nj         = 6'(group_q) * 6'(SLOTS_PER_GROUP) + 6'(j);
      gm[j]      = (nj < 6'(SLOT_COUNT)) && written_q[nj[AW-1:0]];
      hi_mask[j] = (KW'(j) > k_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    group_d    = group_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_o      = '0;
    wr_en      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.burst) begin
            group_d = cmd_i.group;
            k_d     = '0;
            state_d = ST_SCAN;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (slot_ok) begin
          if (!out_full_i) begin
            out_push_o    = 1'b1;
            out_o.tx_byte = tsf_pkg::slot_id(n[4:0]);
            state_d       = ST_HI;
          end
        end else if (k_last) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_HI: begin
        if (!out_full_i) begin
          out_push_o    = 1'b1;
          out_o.tx_byte = rd_q[15:8];
          state_d       = ST_LO;
        end
      end
      ST_LO: begin
        if (!out_full_i) begin
          out_push_o    = 1'b1;
          out_o.tx_byte = rd_q[7:0];
          out_o.last    = last;
          if (k_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      group_q   <= '0;
      written_q <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      group_q <= group_d;
      if (wr_en) begin
        written_q[cmd_i.idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.idx[AW-1:0]] <= cmd_i.value;
    end
    if (state_q == ST_SCAN) begin
      rd_q <= mem[n[AW-1:0]];
    end
  end

endmodule

// File: rtl/core/telemetry_slot_framer_top.sv
// Top level of the telemetry slot framer: front end, command queue, back end, output queue.
// Input words are taken one per cycle while the two-entry command queue has room.
// The back end writes each popped slot write into the slot store; for a burst it dispatches,
// then scans each group slot and sends the slot id, high byte and low byte of each written slot.
// The bytes of a written slot leave one per cycle while the output queue has room.
// Reset clears the frame count, the written flags and both queues, not the slot values.
module telemetry_slot_framer_top #(
  parameter int SLOT_COUNT      = tsf_pkg::SLOT_COUNT_DEF,
  parameter int SLOTS_PER_GROUP = tsf_pkg::SLOTS_PER_GROUP_DEF,
  parameter int FRAME_LENGTH    = tsf_pkg::FRAME_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [4:0]  slot_index_i,
  input  logic [15:0] slot_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);

  logic          accept;
  logic          cmd_push, cmd_pop, cmd_empty;
  tsf_pkg::cmd_t cmd_in, cmd_out;
  logic          out_push, out_full;
  tsf_pkg::out_t out_in, out_out;

  assign accept = push && !full;

  tsf_front #(
    .SLOT_COUNT  (SLOT_COUNT),
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .slot_index_i(slot_index_i),
    .slot_value_i(slot_value_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  tsf_fifo #(
    .WIDTH($bits(tsf_pkg::cmd_t)),
    .DEPTH(tsf_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  tsf_back #(
    .SLOT_COUNT     (SLOT_COUNT),
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_o      (out_in)
  );

  tsf_fifo #(
    .WIDTH($bits(tsf_pkg::out_t)),
    .DEPTH(tsf_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_in),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_out),
    .empty_o(empty)
  );

  assign tx_byte_o   = out_out.tx_byte;
  assign last_byte_o = out_out.last;

endmodule

// File: rtl/core/tsf_checker.sv
// Port-level checker of the telemetry slot framer and its bind to the top level.
module tsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] tx_byte_o,
  input logic       last_byte_o
);

  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("Queues are not cleared while reset is held.");

  a_reset_exit: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("Queues hold words right after reset.");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("Input queue filled up without an incoming word.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(tx_byte_o) && $stable(last_byte_o))
    else $error("A waiting result word changed before it was taken.");

endmodule

bind telemetry_slot_framer_top tsf_checker u_tsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .tx_byte_o  (tx_byte_o),
  .last_byte_o(last_byte_o)
);

// File: tb/telemetry_slot_framer_top_test.sv
// Self-checking testbench for the telemetry slot framer with a scoreboard class and paced drivers.
module telemetry_slot_framer_top_test;

  localparam int SLOT_COUNT      = tsf_pkg::SLOT_COUNT_DEF;
  localparam int SLOTS_PER_GROUP = tsf_pkg::SLOTS_PER_GROUP_DEF;
  localparam int FRAME_LENGTH    = tsf_pkg::FRAME_LENGTH_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_WORDS    = 130;

  typedef enum logic {
    CMD_RX_BYTE    = 1'b0,
    CMD_SLOT_WRITE = 1'b1
  } word_kind_e;

  class slot_burst_scoreboard;
    logic [15:0]   slot_value_mem [SLOT_COUNT];
    bit            slot_valid [SLOT_COUNT];
    int unsigned   frame_count;
    tsf_pkg::out_t burst_bytes_q [$];
    int unsigned   errors;
    int unsigned   bytes_checked;
    int unsigned   bursts;
    int unsigned   silent_frames;
    int unsigned   results_expected;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i]     = 1'b0;
        slot_value_mem[i] = '0;
      end
      frame_count      = 0;
      errors           = 0;
      bytes_checked    = 0;
      bursts           = 0;
      silent_frames    = 0;
      results_expected = 0;
    endfunction

    function logic [7:0] slot_tag(int n);
      logic [7:0] tag;
      tag[2:0] = tsf_pkg::ID_LOW_BITS;
      for (int b = 0; b < 5; b++) begin
        tag[7-b] = n[b];
      end
      return tag;
    endfunction

    function int pending();
      return burst_bytes_q.size();
    endfunction

    function void note_word(word_kind_e kind, logic [7:0] rx, logic [4:0] idx,
                            logic [15:0] val);
      int            grp;
      int            n;
      int            total;
      int            emitted;
      tsf_pkg::out_t item;
      if (kind == CMD_SLOT_WRITE) begin
        if (idx < SLOT_COUNT) begin
          slot_value_mem[idx] = val;
          slot_valid[idx]     = 1'b1;
        end
        return;
      end
      if (frame_count == 0) begin
        if (rx == tsf_pkg::START_BYTE) frame_count = 1;
        return;
      end
      if (frame_count < FRAME_LENGTH - 1) begin
        frame_count++;
        return;
      end
      frame_count = 0;
      case (rx)
        tsf_pkg::END_GROUP0: grp = 0;
        tsf_pkg::END_GROUP1: grp = 1;
        tsf_pkg::END_GROUP2: grp = 2;
        tsf_pkg::END_GROUP3: grp = 3;
        default:             grp = -1;
      endcase
      total = 0;
      if (grp >= 0) begin
        for (int k = 0; k < SLOTS_PER_GROUP; k++) begin
          n = grp * SLOTS_PER_GROUP + k;
          if (n < SLOT_COUNT && slot_valid[n]) total += 3;
        end
      end
      if (total == 0) begin
        silent_frames++;
        return;
      end
      emitted = 0;
      for (int k = 0; k < SLOTS_PER_GROUP; k++) begin
        n = grp * SLOTS_PER_GROUP + k;
        if (n < SLOT_COUNT && slot_valid[n]) begin
          for (int j = 0; j < 3; j++) begin
            case (j)
              0:       item.tx_byte = slot_tag(n);
              1:       item.tx_byte = slot_value_mem[n][15:8];
              default: item.tx_byte = slot_value_mem[n][7:0];
            endcase
            item.last = (emitted == total - 1);
            burst_bytes_q.push_back(item);
            emitted++;
          end
        end
      end
      bursts++;
      results_expected += total;
    endfunction

    function void check_byte(logic [7:0] tx, logic last_flag);
      tsf_pkg::out_t want;
      if (burst_bytes_q.size() == 0) begin
        $error("Unexpected word: tx_byte=%h last_byte=%b", tx, last_flag);
        errors++;
        return;
      end
      want = burst_bytes_q.pop_front();
      bytes_checked++;
      if (tx !== want.tx_byte) begin
        $error("tx_byte mismatch: expected %h, actual %h", want.tx_byte, tx);
        errors++;
      end
      if (last_flag !== want.last) begin
        $error("last_byte mismatch: expected %b, actual %b", want.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic        command_i    = 1'b0;
  logic [7:0]  rx_byte_i    = '0;
  logic [4:0]  slot_index_i = '0;
  logic [15:0] slot_value_i = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        last_byte_o;

  slot_burst_scoreboard sb = new();

  int unsigned cycle_count  = 0;
  int unsigned words_sent   = 0;
  int          burst_left   = 0;
  bit          sender_eager = 1'b0;
  logic [7:0]  stall_pattern = 8'hff;
  int          stall_phase  = 0;

  telemetry_slot_framer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .slot_index_i (slot_index_i),
    .slot_value_i (slot_value_i),
    .empty        (empty),
    .pop          (pop),
    .tx_byte_o    (tx_byte_o),
    .last_byte_o  (last_byte_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_byte(tx_byte_o, last_byte_o);
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 8'hff;
        1:       stall_pattern = 8'h55;
        2:       stall_pattern = 8'h81;
        default: stall_pattern = 8'($urandom_range(0, 255));
      endcase
      stall_pattern[0] = 1'b1;
      stall_phase      = $urandom_range(20, 60);
    end
    stall_phase--;
    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
    pop <= stall_pattern[0];
  end

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 10);
      gap        = sender_eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_word(word_kind_e kind, logic [7:0] rx, logic [4:0] idx,
                           logic [15:0] val);
    push         <= 1'b1;
    command_i    <= kind;
    rx_byte_i    <= rx;
    slot_index_i <= idx;
    slot_value_i <= val;
    do @(posedge clk_i); while (full);
    sb.note_word(kind, rx, idx, val);
    words_sent++;
    pace_sender();
  endtask

  task automatic send_rx(logic [7:0] rx);
    send_word(CMD_RX_BYTE, rx, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_write(logic [4:0] idx, logic [15:0] val);
    send_word(CMD_SLOT_WRITE, 8'($urandom_range(0, 255)), idx, val);
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_end_byte(int frame_no);
    logic [7:0] ends [4];
    int         r;
    ends[0] = tsf_pkg::END_GROUP0;
    ends[1] = tsf_pkg::END_GROUP1;
    ends[2] = tsf_pkg::END_GROUP2;
    ends[3] = tsf_pkg::END_GROUP3;
    if (frame_no < 3) return ends[frame_no == 2 ? 3 : frame_no];
    if (frame_no == 3) return 8'hff;
    r = $urandom_range(0, 9);
    if (r < 8) return ends[r % 4];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int         counted;
    int         frame_no;
    int         choice;
    int         body_len;
    int         n;
    bit         drained_mid;
    logic [4:0] idx;
    logic [7:0] noise;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Group two stays empty here so its end byte gives no burst.
    sender_eager = 1'b1;
    send_write(5'd0,  16'h0000);
    send_write(5'd1,  16'hffff);
    send_write(5'd7,  16'ha5c3);
    send_write(5'd31, 16'h8001);
    send_write(5'd24, 16'h7ffe);
    send_rx(tsf_pkg::START_BYTE);
    send_rx(tsf_pkg::START_BYTE);
    send_rx(8'h00);
    send_write(5'd15, 16'h5a3c);
    send_rx(8'hff);
    for (int i = 0; i < FRAME_LENGTH - 5; i++) send_rx(8'($urandom_range(0, 255)));
    send_rx(tsf_pkg::END_GROUP2);
    hold_until_drained();

    counted     = 0;
    frame_no    = 0;
    drained_mid = 1'b0;
    while (words_sent < RANDOM_WORDS) begin
      choice       = $urandom_range(0, 9);
      sender_eager = ($urandom_range(0, 3) == 0);
      if (choice < 2) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          do idx = 5'($urandom_range(0, 31));
          while (counted < RANDOM_WORDS / 2 && idx[4:3] == 2'd2);
          send_write(idx, 16'($urandom_range(0, 65535)));
          counted++;
        end
      end else if (choice == 2) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do noise = 8'($urandom_range(0, 255));
          while (noise == tsf_pkg::START_BYTE);
          send_rx(noise);
        end
      end else begin
        send_rx(tsf_pkg::START_BYTE);
        counted++;
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, FRAME_LENGTH - 3)
                                                : FRAME_LENGTH - 2;
        for (int i = 0; i < body_len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            do idx = 5'($urandom_range(0, 31));
            while (counted < RANDOM_WORDS / 2 && idx[4:3] == 2'd2);
            send_write(idx, 16'($urandom_range(0, 65535)));
            counted++;
          end
          send_rx(8'($urandom_range(0, 255)));
          counted++;
        end
        if (body_len == FRAME_LENGTH - 2) begin
          send_rx(pick_end_byte(frame_no));
          counted++;
          frame_no++;
        end
      end
      if (!drained_mid && counted >= RANDOM_WORDS / 2) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d words; %0d frames produced telemetry bursts, %0d ended without one.",
             words_sent, sb.bursts, sb.silent_frames);
    $display("Checked %0d of %0d expected telemetry bytes under random gaps and stalls.",
             sb.bytes_checked, sb.results_expected);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
